>>> rtl/tbss_pkg.sv
// Shared types, constants and the arctangent table for the template bank step-size pipeline.
package tbss_pkg;

    localparam int CORDIC_STAGES = 16;

    localparam int MM_W       = 16;
    localparam int N_W        = MM_W + 2;
    localparam int G_W        = 32;
    localparam int Q1_W       = N_W + G_W;
    localparam int SQ_STEPS   = Q1_W / 2;
    localparam int ROOT_W     = SQ_STEPS;
    localparam int SQ_REM_W   = ROOT_W + 3;
    localparam int D_W        = 32;
    localparam int TILT_W     = 16;
    localparam int MAG_SHIFT  = 17;
    localparam int ANG_W      = 35;
    localparam int VXY_W      = 36;
    localparam int RXY_W      = 33;
    localparam int DIV2_STEPS = 32;
    localparam int PROD_W     = 64;
    localparam int FRAC_SHIFT = 30;
    localparam int AXIS_LAT   = Q1_W + SQ_STEPS;

    localparam logic [MM_W:0]               MM_ONE      = 17'h10000;
    localparam logic [MM_W-1:0]             MM_RESET    = 16'd62259;
    localparam logic [D_W-1:0]              MAX32       = 32'hFFFF_FFFF;
    localparam logic signed [ANG_W-1:0]     PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0]     HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [RXY_W-1:0]     CORDIC_GAIN = 33'sd652032874;

    typedef struct packed {
        logic [G_W-1:0]           metric_g00;
        logic [G_W-1:0]           metric_g11;
        logic signed [TILT_W-1:0] tilt_angle;
    } metric_t;

    typedef struct packed {
        logic [D_W-1:0] step_x0;
        logic [D_W-1:0] step_x1;
        logic           sine_branch;
        logic           saturated;
    } step_t;

    typedef struct packed {
        logic valid;
        logic sat;
    } ctl_t;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:       v = 35'sd843314857;
            1:       v = 35'sd497837829;
            2:       v = 35'sd263043837;
            3:       v = 35'sd133525159;
            4:       v = 35'sd67021687;
            5:       v = 35'sd33543516;
            6:       v = 35'sd16775851;
            7:       v = 35'sd8388437;
            8:       v = 35'sd4194283;
            9:       v = 35'sd2097149;
            default: v = (i > 40) ? '0 : ANG_W'(64'd1073741824 >> i);
        endcase
        return v;
    endfunction

endpackage

>>> rtl/tbss_axis.sv
// Axis step: pipelined restoring divide of n*2^32 by g, then pipelined integer square root.
module tbss_axis (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     valid_in,
    input  logic [tbss_pkg::N_W-1:0] num,
    input  logic [tbss_pkg::G_W-1:0] g,
    output tbss_pkg::ctl_t           ctl_out,
    output logic [tbss_pkg::D_W-1:0] d
);
    import tbss_pkg::*;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [N_W-1:0]   num;
        logic [G_W-1:0]   g;
        logic [G_W-1:0]   rem;
        logic [Q1_W-1:0]  q;
    } div_st_t;

    typedef struct packed {
        logic                valid;
        logic                zero;
        logic [Q1_W-1:0]     v;
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } sq_st_t;

    div_st_t div_in;
    div_st_t div_reg [0:Q1_W-1];
    sq_st_t  sq_in;
    sq_st_t  sq_reg [0:SQ_STEPS-1];

    always_comb
    begin
        div_in.valid = valid_in;
        div_in.zero  = (g == '0);
        div_in.num   = num;
        div_in.g     = g;
        div_in.rem   = '0;
        div_in.q     = '0;
    end

    for (genvar k = 0; k < Q1_W; k++)
    begin : g_div
        div_st_t      src;
        div_st_t      st_next;
        logic [G_W:0] rem_sh;
        logic         ge;

        if (k == 0)
        begin : g_src
            assign src = div_in;
        end
        else
        begin : g_src
            assign src = div_reg[k-1];
        end

        always_comb
        begin
            rem_sh      = {src.rem, src.num[N_W-1]};
            ge          = (rem_sh >= {1'b0, src.g});
            st_next     = src;
            st_next.num = src.num << 1;
            st_next.rem = ge ? G_W'(rem_sh - {1'b0, src.g}) : rem_sh[G_W-1:0];
            st_next.q   = {src.q[Q1_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_reg[k].valid <= 1'b0;
            else
                div_reg[k] <= st_next;
        end
    end

    always_comb
    begin
        sq_in.valid = div_reg[Q1_W-1].valid;
        sq_in.zero  = div_reg[Q1_W-1].zero;
        sq_in.v     = div_reg[Q1_W-1].q;
        sq_in.rem   = '0;
        sq_in.root  = '0;
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq
        sq_st_t              src;
        sq_st_t              st_next;
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;
        logic                ge;

        if (k == 0)
        begin : g_src
            assign src = sq_in;
        end
        else
        begin : g_src
            assign src = sq_reg[k-1];
        end

        always_comb
        begin
            rem_sh       = {src.rem[SQ_REM_W-3:0], src.v[Q1_W-1:Q1_W-2]};
            trial        = {1'b0, src.root, 2'b01};
            ge           = (rem_sh >= trial);
            st_next      = src;
            st_next.v    = src.v << 2;
            st_next.rem  = ge ? (rem_sh - trial) : rem_sh;
            st_next.root = {src.root[ROOT_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_reg[k].valid <= 1'b0;
            else
                sq_reg[k] <= st_next;
        end
    end

    assign ctl_out.valid = sq_reg[SQ_STEPS-1].valid;
    assign ctl_out.sat   = sq_reg[SQ_STEPS-1].zero;
    assign d = sq_reg[SQ_STEPS-1].zero ? MAX32 : D_W'(sq_reg[SQ_STEPS-1].root);

endmodule

>>> rtl/tbss_vector.sv
// CORDIC vectoring pipeline: step angle atan2(d1, d0) in Q30, axis steps carried alongside.
module tbss_vector (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tbss_pkg::ctl_t                    ctl_in,
    input  logic [tbss_pkg::D_W-1:0]          d0,
    input  logic [tbss_pkg::D_W-1:0]          d1,
    output tbss_pkg::ctl_t                    ctl_out,
    output logic [tbss_pkg::D_W-1:0]          d0_out,
    output logic [tbss_pkg::D_W-1:0]          d1_out,
    output logic signed [tbss_pkg::ANG_W-1:0] phi
);
    import tbss_pkg::*;

    typedef struct packed {
        ctl_t                    ctl;
        logic [D_W-1:0]          d0;
        logic [D_W-1:0]          d1;
        logic signed [VXY_W-1:0] x;
        logic signed [VXY_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } vec_st_t;

    vec_st_t vec_in;
    vec_st_t vec_reg [0:CORDIC_STAGES-1];

    always_comb
    begin
        vec_in.ctl = ctl_in;
        vec_in.d0  = d0;
        vec_in.d1  = d1;
        vec_in.x   = $signed(VXY_W'(d0));
        vec_in.y   = $signed(VXY_W'(d1));
        vec_in.z   = '0;
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_stage
        vec_st_t                 src;
        vec_st_t                 st_next;
        logic signed [VXY_W-1:0] xs;
        logic signed [VXY_W-1:0] ys;
        logic signed [ANG_W-1:0] at;

        if (k == 0)
        begin : g_src
            assign src = vec_in;
        end
        else
        begin : g_src
            assign src = vec_reg[k-1];
        end

        always_comb
        begin
            xs      = $signed(src.x) >>> k;
            ys      = $signed(src.y) >>> k;
            at      = atan_entry(k);
            st_next = src;
            if (!src.y[VXY_W-1])
            begin
                st_next.x = src.x + ys;
                st_next.y = src.y - xs;
                st_next.z = src.z + at;
            end
            else
            begin
                st_next.x = src.x - ys;
                st_next.y = src.y + xs;
                st_next.z = src.z - at;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vec_reg[k].ctl.valid <= 1'b0;
            else
                vec_reg[k] <= st_next;
        end
    end

    assign ctl_out = vec_reg[CORDIC_STAGES-1].ctl;
    assign d0_out  = vec_reg[CORDIC_STAGES-1].d0;
    assign d1_out  = vec_reg[CORDIC_STAGES-1].d1;
    assign phi     = vec_reg[CORDIC_STAGES-1].z;

endmodule

>>> rtl/tbss_rotate.sv
// CORDIC rotation pipeline: sine and cosine of the tilt magnitude with quadrant reduction.
module tbss_rotate (
    input  logic                              clk,
    input  logic signed [tbss_pkg::ANG_W-1:0] mag,
    output logic signed [tbss_pkg::ANG_W-1:0] mag_out,
    output logic signed [tbss_pkg::RXY_W-1:0] sin_val,
    output logic signed [tbss_pkg::RXY_W-1:0] cos_val
);
    import tbss_pkg::*;

    typedef struct packed {
        logic signed [ANG_W-1:0] mag;
        logic                    sneg;
        logic                    cneg;
        logic signed [RXY_W-1:0] x;
        logic signed [RXY_W-1:0] y;
        logic signed [ANG_W-1:0] r;
    } rot_st_t;

    rot_st_t rot_in;
    rot_st_t rot_reg [0:CORDIC_STAGES-1];
    rot_st_t last;

    always_comb
    begin
        rot_in.mag  = mag;
        rot_in.x    = CORDIC_GAIN;
        rot_in.y    = '0;
        rot_in.sneg = 1'b0;
        rot_in.cneg = 1'b0;
        rot_in.r    = mag;
        if (mag > PI_Q30)
        begin
            rot_in.r    = mag - PI_Q30;
            rot_in.sneg = 1'b1;
            rot_in.cneg = 1'b1;
        end
        else if (mag > HALF_PI_Q30)
        begin
            rot_in.r    = PI_Q30 - mag;
            rot_in.cneg = 1'b1;
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_stage
        rot_st_t                 src;
        rot_st_t                 st_next;
        logic signed [RXY_W-1:0] xs;
        logic signed [RXY_W-1:0] ys;
        logic signed [ANG_W-1:0] at;

        if (k == 0)
        begin : g_src
            assign src = rot_in;
        end
        else
        begin : g_src
            assign src = rot_reg[k-1];
        end

        always_comb
        begin
            xs      = $signed(src.x) >>> k;
            ys      = $signed(src.y) >>> k;
            at      = atan_entry(k);
            st_next = src;
            if (!src.r[ANG_W-1])
            begin
                st_next.x = src.x - ys;
                st_next.y = src.y + xs;
                st_next.r = src.r - at;
            end
            else
            begin
                st_next.x = src.x + ys;
                st_next.y = src.y - xs;
                st_next.r = src.r + at;
            end
        end

        always_ff @(posedge clk)
        begin
            rot_reg[k] <= st_next;
        end
    end

    assign last    = rot_reg[CORDIC_STAGES-1];
    assign mag_out = last.mag;
    assign sin_val = last.sneg ? -last.y : last.y;
    assign cos_val = last.cneg ? -last.x : last.x;

endmodule

>>> rtl/tbss_finish.sv
// Branch select, pipelined Q30 quotient, product and saturation of the two output steps.
module tbss_finish (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tbss_pkg::ctl_t                    ctl_in,
    input  logic [tbss_pkg::D_W-1:0]          d0,
    input  logic [tbss_pkg::D_W-1:0]          d1,
    input  logic signed [tbss_pkg::ANG_W-1:0] phi,
    input  logic signed [tbss_pkg::ANG_W-1:0] mag,
    input  logic signed [tbss_pkg::RXY_W-1:0] sin_val,
    input  logic signed [tbss_pkg::RXY_W-1:0] cos_val,
    output logic                              done,
    output tbss_pkg::step_t                   step
);
    import tbss_pkg::*;

    typedef struct packed {
        ctl_t           ctl;
        logic           sine;
        logic           fpos;
        logic [D_W-1:0] f;
        logic [D_W-1:0] num;
        logic [D_W-1:0] oth;
    } sel_st_t;

    typedef struct packed {
        ctl_t              ctl;
        logic              sine;
        logic              fpos;
        logic              ovf;
        logic [D_W-1:0]    f;
        logic [D_W-1:0]    rem;
        logic [D_W-1:0]    low;
        logic [D_W-1:0]    q;
        logic [PROD_W-1:0] prod;
    } div_st_t;

    sel_st_t                 sel_reg;
    sel_st_t                 sel_next;
    logic signed [RXY_W-1:0] f_sel;
    div_st_t                 div_in;
    div_st_t                 div_reg [0:DIV2_STEPS-1];
    div_st_t                 last;
    logic [PROD_W-FRAC_SHIFT-1:0] p_full;
    logic                    p_ovf;
    step_t                   step_reg;
    step_t                   step_next;
    logic                    done_reg;

    always_comb
    begin
        sel_next.ctl  = ctl_in;
        sel_next.sine = (mag > phi);
        f_sel         = sel_next.sine ? sin_val : cos_val;
        sel_next.fpos = !f_sel[RXY_W-1] && (f_sel != '0);
        sel_next.f    = f_sel[D_W-1:0];
        sel_next.num  = sel_next.sine ? d1 : d0;
        sel_next.oth  = sel_next.sine ? d0 : d1;
        sel_next.ctl.sat = ctl_in.sat | !sel_next.fpos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg.ctl.valid <= 1'b0;
        else
            sel_reg <= sel_next;
    end

    always_comb
    begin
        div_in.ctl  = sel_reg.ctl;
        div_in.sine = sel_reg.sine;
        div_in.fpos = sel_reg.fpos;
        div_in.f    = sel_reg.f;
        div_in.ovf  = ({2'b00, sel_reg.num[D_W-1:2]} >= sel_reg.f);
        div_in.rem  = {2'b00, sel_reg.num[D_W-1:2]};
        div_in.low  = {sel_reg.num[1:0], {(D_W-2){1'b0}}};
        div_in.q    = '0;
        div_in.prod = PROD_W'(sel_reg.oth) * PROD_W'(sel_reg.f);
    end

    for (genvar k = 0; k < DIV2_STEPS; k++)
    begin : g_div
        div_st_t      src;
        div_st_t      st_next;
        logic [D_W:0] rem_sh;
        logic         ge;

        if (k == 0)
        begin : g_src
            assign src = div_in;
        end
        else
        begin : g_src
            assign src = div_reg[k-1];
        end

        always_comb
        begin
            rem_sh      = {src.rem, src.low[D_W-1]};
            ge          = (rem_sh >= {1'b0, src.f});
            st_next     = src;
            st_next.low = src.low << 1;
            st_next.rem = ge ? D_W'(rem_sh - {1'b0, src.f}) : rem_sh[D_W-1:0];
            st_next.q   = {src.q[D_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_reg[k].ctl.valid <= 1'b0;
            else
                div_reg[k] <= st_next;
        end
    end

    assign last   = div_reg[DIV2_STEPS-1];
    assign p_full = last.prod[PROD_W-1:FRAC_SHIFT];
    assign p_ovf  = |p_full[PROD_W-FRAC_SHIFT-1:D_W];

    always_comb
    begin
        step_next.sine_branch = last.sine;
        if (!last.fpos)
        begin
            step_next.step_x0   = MAX32;
            step_next.step_x1   = '0;
            step_next.saturated = 1'b1;
        end
        else
        begin
            step_next.step_x0   = last.ovf ? MAX32 : last.q;
            step_next.step_x1   = p_ovf ? MAX32 : p_full[D_W-1:0];
            step_next.saturated = last.ctl.sat | last.ovf | p_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= last.ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
    end

    assign done = done_reg;
    assign step = step_reg;

endmodule

>>> rtl/template_bank_step_sizes.sv
// From the start transfer to the done strobe: divide and square root, then CORDIC, then select,
// quotient and output registers; the divide and root pipelines work one bit per stage.
// Throughput: one transfer per cycle; busy is always low and each result shows for one cycle.
// Reset clears every valid bit in the pipeline and loads minimal_match with 62259.
// Top level: configuration register, tilt magnitude, axis steps, CORDIC and output stages.
module template_bank_step_sizes (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  tbss_pkg::metric_t         metric,
    input  logic                      cfg_we,
    input  logic [tbss_pkg::MM_W-1:0] cfg_wdata,
    output logic                      done,
    output tbss_pkg::step_t           step
);
    import tbss_pkg::*;

    logic [MM_W-1:0]         mm_reg;
    logic [MM_W:0]           one_minus;
    logic [N_W-1:0]          num;
    logic [TILT_W-1:0]       tilt_abs;
    logic [TILT_W-1:0]       tilt_dly_reg [0:AXIS_LAT-1];
    logic signed [ANG_W-1:0] mag;
    logic                    accept;

    ctl_t                    ctl_a0;
    ctl_t                    ctl_a1;
    ctl_t                    ctl_vin;
    ctl_t                    ctl_vout;
    logic [D_W-1:0]          d0;
    logic [D_W-1:0]          d1;
    logic [D_W-1:0]          d0_v;
    logic [D_W-1:0]          d1_v;
    logic signed [ANG_W-1:0] phi;
    logic signed [ANG_W-1:0] mag_r;
    logic signed [RXY_W-1:0] sin_val;
    logic signed [RXY_W-1:0] cos_val;

    assign busy   = 1'b0;
    assign accept = start & !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mm_reg <= MM_RESET;
        else if (cfg_we)
            mm_reg <= cfg_wdata;
    end

    assign one_minus = MM_ONE - {1'b0, mm_reg};
    assign num       = {one_minus, 1'b0};
    assign tilt_abs  = metric.tilt_angle[TILT_W-1] ? (~metric.tilt_angle + 1'b1)
                                                   : metric.tilt_angle;

    always_ff @(posedge clk)
    begin
        tilt_dly_reg[0] <= tilt_abs;
        for (int k = 1; k < AXIS_LAT; k++)
        begin
            tilt_dly_reg[k] <= tilt_dly_reg[k-1];
        end
    end

    assign mag = $signed(ANG_W'({tilt_dly_reg[AXIS_LAT-1], {MAG_SHIFT{1'b0}}}));

    tbss_axis u_axis0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (accept),
        .num      (num),
        .g        (metric.metric_g00),
        .ctl_out  (ctl_a0),
        .d        (d0)
    );

    tbss_axis u_axis1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (accept),
        .num      (num),
        .g        (metric.metric_g11),
        .ctl_out  (ctl_a1),
        .d        (d1)
    );

    assign ctl_vin.valid = ctl_a0.valid & ctl_a1.valid;
    assign ctl_vin.sat   = ctl_a0.sat | ctl_a1.sat;

    tbss_vector u_vector (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_vin),
        .d0      (d0),
        .d1      (d1),
        .ctl_out (ctl_vout),
        .d0_out  (d0_v),
        .d1_out  (d1_v),
        .phi     (phi)
    );

    tbss_rotate u_rotate (
        .clk     (clk),
        .mag     (mag),
        .mag_out (mag_r),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    tbss_finish u_finish (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_vout),
        .d0      (d0_v),
        .d1      (d1_v),
        .phi     (phi),
        .mag     (mag_r),
        .sin_val (sin_val),
        .cos_val (cos_val),
        .done    (done),
        .step    (step)
    );

endmodule

>>> bench/template_bank_step_sizes_test.sv
// Testbench for template_bank_step_sizes: queued metric items, bit-exact step predictor, checker.
`timescale 1ns / 1ps

module template_bank_step_sizes_test;
    import tbss_pkg::*;

    localparam int LATENCY   = 125;
    localparam int MAX_CYC   = 400000;
    localparam int N_RANDOM  = 1750;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    metric_t metric;
    logic    cfg_we;
    logic [MM_W-1:0] cfg_wdata;
    logic    done;
    step_t   step;

    template_bank_step_sizes dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .metric    (metric),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .step      (step)
    );

    metric_t         pending_items[$];
    step_t           expected_steps[$];
    logic [MM_W-1:0] match_reg;
    int              mismatches;
    int              cycles;
    bit              quiet_stretch;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_q30(int i);
        longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10)
            return tbl[i];
        if (i > 40)
            return 0;
        return longint'(64'd1073741824 >> i);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic step_t compute_steps(metric_t m, logic [MM_W-1:0] mm);
        step_t r;
        bit sat;
        longint unsigned n, d0, d1, num, oth, q, p;
        longint t, mag, x, y, z, xs, ys, ang, s, c, f;
        bit sneg, cneg, sine;
        int nst;
        sat = 0;
        nst = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
        t = longint'(m.tilt_angle);
        mag = ((t < 0) ? -t : t) * 131072;
        n = 2 * (65536 - longint'(mm));
        if (m.metric_g00 == 0)
        begin
            d0 = MAX32;
            sat = 1;
        end
        else
            d0 = int_sqrt((n << 32) / m.metric_g00);
        if (m.metric_g11 == 0)
        begin
            d1 = MAX32;
            sat = 1;
        end
        else
            d1 = int_sqrt((n << 32) / m.metric_g11);
        x = d0;
        y = d1;
        z = 0;
        for (int i = 0; i < nst; i++)
        begin
            xs = shift_floor(x, i);
            ys = shift_floor(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += atan_q30(i);
            end
            else
            begin
                x -= ys; y += xs; z -= atan_q30(i);
            end
        end
        ang = mag;
        sneg = 0;
        cneg = 0;
        if (mag > 64'sd3373259426)
        begin
            ang = mag - 64'sd3373259426; sneg = 1; cneg = 1;
        end
        else if (mag > 64'sd1686629713)
        begin
            ang = 64'sd3373259426 - mag; cneg = 1;
        end
        x = 652032874;
        y = 0;
        for (int i = 0; i < nst; i++)
        begin
            xs = shift_floor(x, i);
            ys = shift_floor(y, i);
            if (ang >= 0)
            begin
                x -= ys; y += xs; ang -= atan_q30(i);
            end
            else
            begin
                x += ys; y -= xs; ang += atan_q30(i);
            end
        end
        s = sneg ? -y : y;
        c = cneg ? -x : x;
        sine = mag > z;
        if (!sine)
        begin
            f = c; num = d0; oth = d1;
        end
        else
        begin
            f = s; num = d1; oth = d0;
        end
        if (f <= 0)
        begin
            sat = 1; q = MAX32; p = 0;
        end
        else
        begin
            q = (num << 30) / $unsigned(f);
            p = (oth * $unsigned(f)) >> 30;
            if (q > MAX32)
            begin
                q = MAX32; sat = 1;
            end
            if (p > MAX32)
            begin
                p = MAX32; sat = 1;
            end
        end
        r.step_x0 = q[31:0];
        r.step_x1 = p[31:0];
        r.sine_branch = sine;
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic [31:0] rand_metric();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, 255);
            3:       return $urandom;
            default: return $urandom_range(32'h0000_1000, 32'h0100_0000);
        endcase
    endfunction

    function automatic metric_t rand_item();
        metric_t m;
        m.metric_g00 = rand_metric();
        m.metric_g11 = rand_metric();
        if ($urandom_range(0, 19) == 0)
            m.tilt_angle = 16'($urandom);
        else
            m.tilt_angle = 16'($urandom_range(0, 51472) - 25736);
        return m;
    endfunction

    function automatic metric_t make_item(logic [31:0] a, logic [31:0] b, logic [15:0] t);
        metric_t m;
        m.metric_g00 = a;
        m.metric_g11 = b;
        m.tilt_angle = t;
        return m;
    endfunction

    // idle-phase register write; only called with nothing in flight
    task automatic write_match(logic [MM_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        match_reg = v;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_steps.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !busy && pending_items.size() == 0)
            start <= 1'b0;
        else if (pending_items.size() != 0 && (quiet_stretch || $urandom_range(0, 99) >= 10))
        begin
            start  <= 1'b1;
            metric <= pending_items[0];
        end
        else
            start <= 1'b0;
    end

    // predict at acceptance; pop on the same edge
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            expected_steps.push_back(compute_steps(metric, match_reg));
            void'(pending_items.pop_front());
        end
    end

    // monitor
    always @(posedge clk)
    begin
        step_t e;
        if (rst_n && done)
        begin
            if (expected_steps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %h", step);
            end
            else
            begin
                e = expected_steps.pop_front();
                if (step !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x0=%h x1=%h sin=%b sat=%b",
                                 e.step_x0, e.step_x1, e.sine_branch, e.saturated,
                                 " got x0=%h x1=%h sin=%b sat=%b",
                                 step.step_x0, step.step_x1, step.sine_branch,
                                 step.saturated);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYC)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [MM_W-1:0] settings[5] = '{16'd0, 16'hFFFF, 16'd32768, 16'd65000, 16'd40000};
        int per_phase;
        mismatches    = 0;
        cycles        = 0;
        quiet_stretch = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        metric    = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        match_reg = MM_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pending_items.push_back(make_item(32'h0001_0000, 32'h0001_0000, 16'sd0));
        pending_items.push_back(make_item(32'h0, 32'h0001_0000, 16'sd1000));
        pending_items.push_back(make_item(32'h0001_0000, 32'h0, 16'sd1000));
        pending_items.push_back(make_item(32'h0, 32'h0, 16'sd0));
        pending_items.push_back(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sd25736));
        pending_items.push_back(make_item(32'h1, 32'h1, -16'sd25736));
        pending_items.push_back(make_item(32'h1, 32'hFFFF_FFFF, 16'sd12868));
        pending_items.push_back(make_item(32'hFFFF_FFFF, 32'h1, 16'sd12868));
        pending_items.push_back(make_item(32'h0004_0000, 32'h0001_0000, 16'sd20000));
        pending_items.push_back(make_item(32'h0001_0000, 32'h0004_0000, 16'sd3000));
        pending_items.push_back(make_item(32'h0002_0000, 32'h0002_0000, 16'sh7FFF));
        pending_items.push_back(make_item(32'h0002_0000, 32'h0002_0000, 16'sh8000));
        pending_items.push_back(make_item(32'h0001_0000, 32'h0001_0000, 16'sd6434));
        pending_items.push_back(make_item(32'h0001_0000, 32'h0001_0000, -16'sd6435));
        pending_items.push_back(make_item(32'hAAAA_5555, 32'h5555_AAAA, 16'sd12869));
        drain();

        per_phase = N_RANDOM / 5;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_match(settings[ph]);
            for (int k = 0; k < per_phase; k++)
                pending_items.push_back(rand_item());
            quiet_stretch = (ph == 2);
            drain();
            quiet_stretch = 0;
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> template_bank_step_sizes.f
rtl/tbss_pkg.sv
rtl/tbss_axis.sv
rtl/tbss_vector.sv
rtl/tbss_rotate.sv
rtl/tbss_finish.sv
rtl/template_bank_step_sizes.sv
bench/template_bank_step_sizes_test.sv
